/* rtl/sis_pkg.sv */
// Shared types, codes and helper functions for the sorted integer set.
// Used by sis_cell, sis_reduce and sorted_integer_set. No dependencies.
`timescale 1ns / 1ps

package sis_pkg;

    // Number of cells in the chain, the most elements the set can hold.
    localparam int CAPACITY_DEF = 256;

    // Field widths of the streaming ports.
    localparam int VALUE_W  = 64;
    localparam int INDEX_W  = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 9;
    localparam int ENC_W    = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 88;

    // Request kinds carried in tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_NONE = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // Element encodings, narrowest first.
    typedef enum logic [ENC_W-1:0] {
        ENC_16 = 2'd0,
        ENC_32 = 2'd1,
        ENC_64 = 2'd2
    } enc_t;

    // Sequencer states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // What every cell does with its stored element at the update edge.
    typedef enum logic [1:0] {
        UPD_HOLD   = 2'd0,
        UPD_INSERT = 2'd1,
        UPD_REMOVE = 2'd2
    } upd_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic capture;  // latch the compare flags against the incoming item
        upd_t upd;      // shift action for the update edge
    } cell_ctrl_t;

    // Narrowest encoding that holds v.
    function automatic enc_t need_enc(input logic [VALUE_W-1:0] v);
        enc_t code;
        if ((&v[VALUE_W-1:15]) || !(|v[VALUE_W-1:15])) begin
            code = ENC_16;
        end else if ((&v[VALUE_W-1:31]) || !(|v[VALUE_W-1:31])) begin
            code = ENC_32;
        end else begin
            code = ENC_64;
        end
        return code;
    endfunction

endpackage

/* rtl/sis_cell.sv */
// One cell of the sorted chain: holds one element and its compare flags.
// Depends on sis_pkg for the control struct and field widths.
`timescale 1ns / 1ps

module sis_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sis_pkg::cell_ctrl_t         ctrl,
    input  logic [sis_pkg::VALUE_W-1:0] cmp_value,   // value of the incoming item
    input  logic [sis_pkg::INDEX_W-1:0] cmp_index,   // index of the incoming item
    input  logic [sis_pkg::VALUE_W-1:0] ins_value,   // value being inserted
    input  logic [CNT_W-1:0]            count,
    input  logic [sis_pkg::VALUE_W-1:0] left_data,
    input  logic                        left_lt,
    input  logic [sis_pkg::VALUE_W-1:0] right_data,
    output logic [sis_pkg::VALUE_W-1:0] data,
    output logic                        lt,
    output logic                        eq,
    output logic                        sel
);

    logic [sis_pkg::VALUE_W-1:0] data_reg;
    logic [sis_pkg::VALUE_W-1:0] data_next;
    logic                        lt_reg;
    logic                        lt_next;
    logic                        eq_reg;
    logic                        eq_next;
    logic                        sel_reg;
    logic                        sel_next;
    logic                        occupied;

    // The cell holds a live element when its place is below the count.
    assign occupied = (32'(IDX) < 32'(count));

    // Compare flags against the incoming item, latched when it is accepted.
    always_comb
    begin
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        sel_next = sel_reg;
        if (ctrl.capture) begin
            lt_next  = occupied && ($signed(data_reg) < $signed(cmp_value));
            eq_next  = occupied && (data_reg == cmp_value);
            sel_next = (32'(IDX) == 32'(cmp_index));
        end
    end

    // Shift the element up on an insert, down on a remove.
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.upd)
            sis_pkg::UPD_INSERT:
            begin
                if (!lt_reg) begin
                    data_next = left_lt ? ins_value : left_data;
                end
            end
            sis_pkg::UPD_REMOVE:
            begin
                if (!lt_reg) begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Flags reset to cleared; the element itself is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end else begin
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign lt   = lt_reg;
    assign eq   = eq_reg;
    assign sel  = sel_reg;

endmodule

/* rtl/sis_reduce.sv */
// Collects the chain's flags into a position, a match and a read element.
// Depends on sis_pkg for field widths.
`timescale 1ns / 1ps

module sis_reduce #(
    parameter int CAPACITY = sis_pkg::CAPACITY_DEF,
    parameter int PW       = $clog2(CAPACITY + 1)
) (
    input  logic [CAPACITY-1:0]         lt,
    input  logic [CAPACITY-1:0]         eq,
    input  logic [CAPACITY-1:0]         sel,
    input  logic [sis_pkg::VALUE_W-1:0] data [CAPACITY],
    output logic [PW-1:0]               pos,
    output logic                        found,
    output logic [sis_pkg::VALUE_W-1:0] rd_data
);

    logic [CAPACITY-1:0] bnd;

    // The less-than flags form a thermometer; its edge marks the position.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == 0) begin
                bnd[i] = !lt[i];
            end else begin
                bnd[i] = !lt[i] && lt[i-1];
            end
        end
    end

    // Encode the edge, test the match there and read the selected cell.
    always_comb
    begin
        pos     = lt[CAPACITY-1] ? PW'(CAPACITY) : '0;
        found   = 1'b0;
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pos     = pos | (bnd[i] ? PW'(i) : '0);
            found   = found | (bnd[i] & eq[i]);
            rd_data = rd_data | (sel[i] ? data[i] : '0);
        end
    end

endmodule

/* rtl/sorted_integer_set.sv */
// Top level of the sorted integer set: request stream in, one result item out.
// Depends on sis_pkg, sis_cell and sis_reduce.
`timescale 1ns / 1ps

// The set is a chain of CAPACITY cells, one element per cell, kept in
// ascending signed order with no duplicates. Each request (add, remove, find
// or get, selected by s_tuser) runs in two steps: at the accept edge every cell
// compares its element with the request, and at the update edge, once the
// output register is free or draining, the flags are reduced to a position,
// neighbors shift by one place for an add or remove, and the result item is
// loaded into the output register. The block takes the next request in the
// cycle after that, so requests never overlap in the cell chain; a result
// that waits at the output holds the update step until the earlier one is taken.
// After reset the set is empty with int16 encoding, and the encoding code only
// ever widens.
module sorted_integer_set #(
    parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value[63:0], index[71:64]
    input  logic [sis_pkg::IN_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [sis_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], result_value[65:2], position[74:66], count[83:75],
    // width_code[85:84], zero[87:86]
    output logic [sis_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int VW = sis_pkg::VALUE_W;

    sis_pkg::state_t             state_reg;
    sis_pkg::state_t             state_next;
    sis_pkg::op_t                op_reg;
    logic [VW-1:0]               value_reg;
    logic [sis_pkg::INDEX_W-1:0] index_reg;
    logic [PW-1:0]               count_reg;
    logic [PW-1:0]               count_next;
    sis_pkg::enc_t               enc_reg;
    sis_pkg::enc_t               enc_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [sis_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [sis_pkg::OUT_DATA_W-1:0] out_data_next;

    logic                        accept;
    logic                        load;
    sis_pkg::cell_ctrl_t         ctrl;
    logic [VW-1:0]               in_value;
    logic [sis_pkg::INDEX_W-1:0] in_index;

    logic [VW-1:0]               cell_data [CAPACITY];
    logic [CAPACITY-1:0]         cell_lt;
    logic [CAPACITY-1:0]         cell_eq;
    logic [CAPACITY-1:0]         cell_sel;

    logic [PW-1:0]               pos;
    logic                        found;
    logic [VW-1:0]               rd_data;

    sis_pkg::status_t            res_status;
    logic [VW-1:0]               res_value;
    logic [sis_pkg::POS_W-1:0]   res_pos;
    sis_pkg::enc_t               add_enc;

    assign in_value = s_tdata[VW-1:0];
    assign in_index = s_tdata[VW+sis_pkg::INDEX_W-1:VW];
    assign s_tready = (state_reg == sis_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == sis_pkg::S_EXEC) && (!out_valid_reg || m_tready);
    assign add_enc  = sis_pkg::need_enc(value_reg);

    // Chain of cells; each sees its left and right neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VW-1:0] left_data;
        logic          left_lt;
        logic [VW-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = value_reg;
            assign left_lt   = 1'b1;
        end else begin : g_mid
            assign left_data = cell_data[g-1];
            assign left_lt   = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_inner
            assign right_data = cell_data[g+1];
        end

        sis_cell #(
            .IDX   (g),
            .CNT_W (PW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cmp_value  (in_value),
            .cmp_index  (in_index),
            .ins_value  (value_reg),
            .count      (count_reg),
            .left_data  (left_data),
            .left_lt    (left_lt),
            .right_data (right_data),
            .data       (cell_data[g]),
            .lt         (cell_lt[g]),
            .eq         (cell_eq[g]),
            .sel        (cell_sel[g])
        );
    end

    sis_reduce #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_reduce (
        .lt      (cell_lt),
        .eq      (cell_eq),
        .sel     (cell_sel),
        .data    (cell_data),
        .pos     (pos),
        .found   (found),
        .rd_data (rd_data)
    );

    // Sequencer, result formation and state update.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        enc_next       = enc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ctrl.capture   = accept;
        ctrl.upd       = sis_pkg::UPD_HOLD;
        res_status     = sis_pkg::STAT_NONE;
        res_value      = value_reg;
        res_pos        = sis_pkg::POS_W'(pos);

        case (op_reg)
            sis_pkg::OP_ADD:
            begin
                if (found) begin
                    res_status = sis_pkg::STAT_NONE;
                end else if (32'(count_reg) >= CAPACITY) begin
                    res_status = sis_pkg::STAT_FULL;
                end else begin
                    res_status = sis_pkg::STAT_DONE;
                    ctrl.upd   = load ? sis_pkg::UPD_INSERT : sis_pkg::UPD_HOLD;
                    if (load) begin
                        count_next = count_reg + PW'(1);
                        if (add_enc > enc_reg) begin
                            enc_next = add_enc;
                        end
                    end
                end
            end
            sis_pkg::OP_REMOVE:
            begin
                if (found) begin
                    res_status = sis_pkg::STAT_DONE;
                    ctrl.upd   = load ? sis_pkg::UPD_REMOVE : sis_pkg::UPD_HOLD;
                    if (load) begin
                        count_next = count_reg - PW'(1);
                    end
                end
            end
            sis_pkg::OP_FIND:
            begin
                res_status = found ? sis_pkg::STAT_DONE : sis_pkg::STAT_NONE;
            end
            sis_pkg::OP_GET:
            begin
                res_pos = sis_pkg::POS_W'(index_reg);
                if ((32'(index_reg) < 32'(count_reg)) && (32'(index_reg) < CAPACITY)) begin
                    res_status = sis_pkg::STAT_DONE;
                    res_value  = rd_data;
                end
            end
            default:
            begin
                res_status = sis_pkg::STAT_NONE;
            end
        endcase

        case (state_reg)
            sis_pkg::S_IDLE:
            begin
                if (accept) begin
                    state_next = sis_pkg::S_EXEC;
                end
            end
            sis_pkg::S_EXEC:
            begin
                if (load) begin
                    state_next     = sis_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, enc_next, sis_pkg::POS_W'(count_next),
                                      res_pos, res_value, res_status};
                end
            end
            default:
            begin
                state_next = sis_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= sis_pkg::S_IDLE;
            count_reg     <= '0;
            enc_reg       <= sis_pkg::ENC_16;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            enc_reg       <= enc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg    <= sis_pkg::op_t'(s_tuser);
            value_reg <= in_value;
            index_reg <= in_index;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The element count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("element count above capacity");

    // The encoding never narrows.
    a_enc_widen: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (enc_reg >= $past(enc_reg)))
        else $error("encoding narrowed");

    // Count and encoding change only at the update edge.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> ($stable(count_reg) && $stable(enc_reg)))
        else $error("set state changed outside an update");

    // An accepted item always leads to the execute step.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == sis_pkg::S_EXEC))
        else $error("accepted item not executed");

    // A result loads only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("waiting result overwritten");

endmodule

/* dv/sorted_integer_set_test.sv */
// Self-checking testbench for sorted_integer_set: directed and random request items.
// Depends on sis_pkg and the sorted_integer_set RTL. It reads no files.
`timescale 1ns / 1ps

module sorted_integer_set_test;

    localparam int SET_CAPACITY = sis_pkg::CAPACITY_DEF;
    // Sized for roughly 1000 items under the heaviest idling, several times over.
    localparam int CYCLE_LIMIT = 300000;
    localparam int NUM_DIRECTED = 22;

    // One result item, unpacked from m_tdata.
    typedef struct packed {
        sis_pkg::status_t status;
        logic [63:0]      value;
        logic [8:0]       position;
        logic [8:0]       count;
        sis_pkg::enc_t    width;
    } set_result_t;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct packed {
        sis_pkg::op_t op;
        logic [63:0]  value;
        logic [7:0]   index;
        logic         typed;
        set_result_t  typed_res;
    } dir_row_t;

    localparam set_result_t NO_RESULT =
        '{sis_pkg::STAT_DONE, 64'h0, 9'd0, 9'd0, sis_pkg::ENC_16};

    localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // Requests against the empty set after reset.
        '{sis_pkg::OP_GET, 64'h0123_4567_89AB_CDEF, 8'd0, 1'b1,
          '{sis_pkg::STAT_NONE, 64'h0123_4567_89AB_CDEF, 9'd0, 9'd0, sis_pkg::ENC_16}},
        '{sis_pkg::OP_FIND, 64'd5, 8'd0, 1'b1,
          '{sis_pkg::STAT_NONE, 64'd5, 9'd0, 9'd0, sis_pkg::ENC_16}},
        '{sis_pkg::OP_REMOVE, 64'd5, 8'd0, 1'b1,
          '{sis_pkg::STAT_NONE, 64'd5, 9'd0, 9'd0, sis_pkg::ENC_16}},
        // First add, then a duplicate add.
        '{sis_pkg::OP_ADD, 64'd0, 8'd0, 1'b1,
          '{sis_pkg::STAT_DONE, 64'd0, 9'd0, 9'd1, sis_pkg::ENC_16}},
        '{sis_pkg::OP_ADD, 64'd0, 8'd0, 1'b1,
          '{sis_pkg::STAT_NONE, 64'd0, 9'd0, 9'd1, sis_pkg::ENC_16}},
        // Edges of the int16 range keep the narrow encoding.
        '{sis_pkg::OP_ADD, 64'h7FFF, 8'd0, 1'b1,
          '{sis_pkg::STAT_DONE, 64'h7FFF, 9'd1, 9'd2, sis_pkg::ENC_16}},
        '{sis_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_8000, 8'd0, 1'b1,
          '{sis_pkg::STAT_DONE, 64'hFFFF_FFFF_FFFF_8000, 9'd0, 9'd3, sis_pkg::ENC_16}},
        // Widening to int32: positive goes at the end, negative at the front.
        '{sis_pkg::OP_ADD, 64'h8000, 8'd0, 1'b1,
          '{sis_pkg::STAT_DONE, 64'h8000, 9'd3, 9'd4, sis_pkg::ENC_32}},
        '{sis_pkg::OP_ADD, 64'hFFFF_FFFF_8000_0000, 8'd0, 1'b1,
          '{sis_pkg::STAT_DONE, 64'hFFFF_FFFF_8000_0000, 9'd0, 9'd5, sis_pkg::ENC_32}},
        '{sis_pkg::OP_ADD, 64'h7FFF_FFFF, 8'd0, 1'b1,
          '{sis_pkg::STAT_DONE, 64'h7FFF_FFFF, 9'd5, 9'd6, sis_pkg::ENC_32}},
        // Min and max reads, then reads out of range.
        '{sis_pkg::OP_GET, 64'h0, 8'd0, 1'b1,
          '{sis_pkg::STAT_DONE, 64'hFFFF_FFFF_8000_0000, 9'd0, 9'd6, sis_pkg::ENC_32}},
        '{sis_pkg::OP_GET, 64'h0, 8'd5, 1'b1,
          '{sis_pkg::STAT_DONE, 64'h7FFF_FFFF, 9'd5, 9'd6, sis_pkg::ENC_32}},
        '{sis_pkg::OP_GET, 64'hDEAD, 8'd6, 1'b1,
          '{sis_pkg::STAT_NONE, 64'hDEAD, 9'd6, 9'd6, sis_pkg::ENC_32}},
        '{sis_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b1,
          '{sis_pkg::STAT_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 9'd255, 9'd6, sis_pkg::ENC_32}},
        // Finds and removes, present and absent, at the front and at the back, then an add and a get.
        '{sis_pkg::OP_FIND, 64'h7FFF, 8'd3, 1'b0, NO_RESULT},
        '{sis_pkg::OP_FIND, 64'd100, 8'd0, 1'b0, NO_RESULT},
        '{sis_pkg::OP_REMOVE, 64'd0, 8'd0, 1'b0, NO_RESULT},
        '{sis_pkg::OP_REMOVE, 64'd0, 8'd0, 1'b0, NO_RESULT},
        '{sis_pkg::OP_REMOVE, 64'hFFFF_FFFF_8000_0000, 8'd0, 1'b0, NO_RESULT},
        '{sis_pkg::OP_REMOVE, 64'h7FFF_FFFF, 8'd0, 1'b0, NO_RESULT},
        '{sis_pkg::OP_ADD, 64'd1, 8'd0, 1'b0, NO_RESULT},
        '{sis_pkg::OP_GET, 64'h5555_5555_5555_5555, 8'hAA, 1'b0, NO_RESULT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = sis_pkg::OP_ADD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    // Shadow copy of the set kept by the predictor.
    logic [63:0]   model_elems [SET_CAPACITY];
    int            model_count = 0;
    sis_pkg::enc_t model_enc = sis_pkg::ENC_16;

    set_result_t pending_results [$];
    int          error_count = 0;
    int          results_checked = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    sorted_integer_set dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] sext32(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

    // Narrowest encoding whose signed range holds v.
    function automatic sis_pkg::enc_t encoding_for(input logic [63:0] v);
        sis_pkg::enc_t code;
        if ($signed(v) >= -64'sd32768 && $signed(v) <= 64'sd32767) begin
            code = sis_pkg::ENC_16;
        end else if ($signed(v) >= -64'sd2147483648 && $signed(v) <= 64'sd2147483647) begin
            code = sis_pkg::ENC_32;
        end else begin
            code = sis_pkg::ENC_64;
        end
        return code;
    endfunction

    // Applies one request to the shadow set and returns the result it causes.
    function automatic set_result_t apply_request(input sis_pkg::op_t op,
                                                  input logic [63:0] v,
                                                  input logic [7:0] idx);
        set_result_t   res;
        int            pos;
        int            k;
        logic          hit;
        sis_pkg::enc_t need;
        res.status = sis_pkg::STAT_NONE;
        res.value = v;
        res.position = '0;
        if (op == sis_pkg::OP_GET) begin
            res.position = {1'b0, idx};
            if (idx < model_count) begin
                res.status = sis_pkg::STAT_DONE;
                res.value = model_elems[idx];
            end
        end else begin
            // Position is the number of elements below v.
            pos = 0;
            while (pos < model_count && $signed(model_elems[pos]) < $signed(v)) begin
                pos++;
            end
            hit = (pos < model_count) && (model_elems[pos] == v);
            res.position = pos[8:0];
            case (op)
                sis_pkg::OP_ADD:
                begin
                    if (hit) begin
                        res.status = sis_pkg::STAT_NONE;
                    end else if (model_count >= SET_CAPACITY) begin
                        res.status = sis_pkg::STAT_FULL;
                    end else begin
                        for (k = model_count; k > pos; k--) begin
                            model_elems[k] = model_elems[k-1];
                        end
                        model_elems[pos] = v;
                        model_count++;
                        need = encoding_for(v);
                        if (need > model_enc) begin
                            model_enc = need;
                        end
                        res.status = sis_pkg::STAT_DONE;
                    end
                end
                sis_pkg::OP_REMOVE:
                begin
                    if (hit) begin
                        for (k = pos; k + 1 < model_count; k++) begin
                            model_elems[k] = model_elems[k+1];
                        end
                        model_count--;
                        res.status = sis_pkg::STAT_DONE;
                    end
                end
                default:
                begin
                    res.status = hit ? sis_pkg::STAT_DONE : sis_pkg::STAT_NONE;
                end
            endcase
        end
        res.count = model_count[8:0];
        res.width = model_enc;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        error_count++;
        $display("MISMATCH in result item %0d, %s: got %h, expected %h",
                 results_checked, field, got_v, want_v);
    endtask

    // Offers one item, with random idle cycles first, and records its expected
    // result once it is accepted. Valid stays high on return.
    task automatic send_item(input sis_pkg::op_t op, input logic [63:0] val,
                             input logic [7:0] idx, input logic typed,
                             input set_result_t typed_res);
        set_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {idx, val};
        s_tuser <= op;
        do begin
            @(posedge clk);
        end while (!s_tready);
        predicted = apply_request(op, val, idx);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Random request drawn against the current set contents. Narrow values stay
    // within int32 so the set can be filled before the widest encoding appears.
    task automatic send_random(input int add_pct, input logic wide);
        int           r_op;
        int           kind;
        int           small_val;
        sis_pkg::op_t op;
        logic [63:0]  v;
        logic [7:0]   idx;
        r_op = $urandom_range(99);
        if (r_op < add_pct) begin
            op = sis_pkg::OP_ADD;
        end else begin
            case (r_op % 3)
                0: op = sis_pkg::OP_REMOVE;
                1: op = sis_pkg::OP_FIND;
                default: op = sis_pkg::OP_GET;
            endcase
        end
        kind = $urandom_range(9);
        if (kind <= 3 && model_count > 0) begin
            v = model_elems[$urandom_range(model_count - 1)];
        end else if (kind <= 5) begin
            small_val = int'($urandom_range(80)) - 40;
            v = sext32(small_val);
        end else if (kind <= 8) begin
            v = wide ? {$urandom, $urandom} : sext32($urandom);
        end else if (wide) begin
            case ($urandom_range(3))
                0: v = 64'h8000_0000_0000_0000;
                1: v = 64'h7FFF_FFFF_FFFF_FFFF;
                2: v = 64'hFFFF_FFFF_FFFF_FFFF;
                default: v = 64'h0000_0001_0000_0000;
            endcase
        end else begin
            case ($urandom_range(3))
                0: v = sext32(32'h8000_0000);
                1: v = sext32(32'h7FFF_FFFF);
                2: v = sext32(32'hFFFF_8000);
                default: v = sext32(32'h0000_7FFF);
            endcase
        end
        if (op == sis_pkg::OP_GET && model_count > 0 && $urandom_range(9) < 7) begin
            idx = 8'($urandom_range(model_count - 1));
        end else begin
            idx = 8'($urandom_range(255));
        end
        send_item(op, v, idx, 1'b0, NO_RESULT);
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Result side: random back-pressure and field-by-field comparison.
    always @(posedge clk)
    begin : result_check
        set_result_t got;
        set_result_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                got.status = sis_pkg::status_t'(m_tdata[1:0]);
                got.value = m_tdata[65:2];
                got.position = m_tdata[74:66];
                got.count = m_tdata[83:75];
                got.width = sis_pkg::enc_t'(m_tdata[85:84]);
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result item", m_tdata[65:2], 64'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    end
                    if (got.value !== want.value) begin
                        report_mismatch("result_value", got.value, want.value);
                    end
                    if (got.position !== want.position) begin
                        report_mismatch("position", 64'(got.position), 64'(want.position));
                    end
                    if (got.count !== want.count) begin
                        report_mismatch("count", 64'(got.count), 64'(want.count));
                    end
                    if (got.width !== want.width) begin
                        report_mismatch("width_code", 64'(got.width), 64'(want.width));
                    end
                    if (m_tdata[87:86] !== 2'b00) begin
                        report_mismatch("padding", 64'(m_tdata[87:86]), 64'h0);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No idling: directed table, then mixed traffic within int32.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].index,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_res);
        end
        repeat (120) send_random(45, 1'b0);
        wait_for_results();

        // Sender idling: fill the set, probe it while full, then mixed traffic.
        send_idle_pct = 63;
        while (model_count < SET_CAPACITY) begin
            send_item(sis_pkg::OP_ADD, sext32($urandom), 8'($urandom_range(255)),
                      1'b0, NO_RESULT);
        end
        // A wide value while full must neither go in nor widen the encoding.
        send_item(sis_pkg::OP_ADD, 64'h8000_0000_0000_0000, 8'd0, 1'b0, NO_RESULT);
        send_item(sis_pkg::OP_ADD, model_elems[17], 8'd0, 1'b0, NO_RESULT);
        send_item(sis_pkg::OP_GET, 64'h0, 8'd255, 1'b0, NO_RESULT);
        send_item(sis_pkg::OP_FIND, model_elems[SET_CAPACITY-1], 8'd0, 1'b0, NO_RESULT);
        repeat (50) send_random(50, 1'b0);
        wait_for_results();

        // Receiver stalling: full 64-bit values, widening to int64.
        send_idle_pct = 0;
        recv_stall_pct = 63;
        repeat (150) send_random(40, 1'b1);

        // Both sides idling, then drain the set and poke the empty set.
        send_idle_pct = 27;
        recv_stall_pct = 27;
        repeat (150) send_random(30, 1'b1);
        while (model_count > 0) begin
            send_item(sis_pkg::OP_REMOVE, model_elems[$urandom_range(model_count - 1)],
                      8'($urandom_range(255)), 1'b0, NO_RESULT);
        end
        repeat (10) send_random(30, 1'b1);

        wait_for_results();
        repeat (10) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
